// ----- src/b85_pkg.sv -----
package b85_pkg;

	// Default width of the character position counters.
	localparam int POSITION_BITS_DEFAULT = 32;

	// Kind code of one result item.
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	// What the character itself contributes to the results of its item.
	typedef enum logic [1:0] {
		HEAD_NONE,
		HEAD_ERROR,
		HEAD_BYTES
	} head_t;

	// Class of one raw character.
	typedef struct packed {
		logic       is_nul;
		logic       is_space;
		logic       is_digit;
		logic [6:0] value;
	} char_class_t;

	// Everything one accepted character hands to the result side.
	typedef struct packed {
		head_t       head;
		logic [31:0] err_pos;
		logic [31:0] word;
		logic        fin;
		logic [2:0]  fin_cnt;
		logic [31:0] fin_gv;
		logic [31:0] fin_ldi;
		logic [31:0] fin_total;
	} bundle_t;

	// Largest prefix of four digits that can still be followed by a fifth.
	localparam logic [31:0] GROUP4_MAX = 32'h0303_0303;

	// Maps a character onto the 85-symbol alphabet
	// 0-9 A-Z a-z ! # $ % & ( ) * + - ; < = > ? @ ^ _ ` { | } ~
	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		r = '0;
		priority if (c == 8'd0) begin
			r.is_nul = 1'b1;
		end else if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
			r.is_space = 1'b1;
		end else if (c >= 8'd48 && c <= 8'd57) begin
			r.is_digit = 1'b1;
			r.value    = 7'(c - 8'd48);
		end else if (c >= 8'd65 && c <= 8'd90) begin
			r.is_digit = 1'b1;
			r.value    = 7'(c - 8'd55);
		end else if (c >= 8'd97 && c <= 8'd122) begin
			r.is_digit = 1'b1;
			r.value    = 7'(c - 8'd61);
		end else begin
			r.is_digit = 1'b1;
			unique case (c)
				8'd33:   r.value = 7'd62;
				8'd35:   r.value = 7'd63;
				8'd36:   r.value = 7'd64;
				8'd37:   r.value = 7'd65;
				8'd38:   r.value = 7'd66;
				8'd40:   r.value = 7'd67;
				8'd41:   r.value = 7'd68;
				8'd42:   r.value = 7'd69;
				8'd43:   r.value = 7'd70;
				8'd45:   r.value = 7'd71;
				8'd59:   r.value = 7'd72;
				8'd60:   r.value = 7'd73;
				8'd61:   r.value = 7'd74;
				8'd62:   r.value = 7'd75;
				8'd63:   r.value = 7'd76;
				8'd64:   r.value = 7'd77;
				8'd94:   r.value = 7'd78;
				8'd95:   r.value = 7'd79;
				8'd96:   r.value = 7'd80;
				8'd123:  r.value = 7'd81;
				8'd124:  r.value = 7'd82;
				8'd125:  r.value = 7'd83;
				8'd126:  r.value = 7'd84;
				default: r.is_digit = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- src/b85_front.sv -----
module b85_front #(
	parameter int POSITION_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             text_valid,
	output logic             text_ready,
	input  logic [7:0]       text_char,
	input  logic             end_of_text,
	input  logic             bundle_ready,
	output logic             push,
	output b85_pkg::bundle_t bundle
);
	import b85_pkg::*;

	// Input register.
	logic                     valid_s1;
	logic [7:0]               char_s1;
	logic                     eot_s1;

	// Message state.
	logic                     stop_q;
	logic [31:0]              gv_q;
	logic [2:0]               cnt_q;
	logic [POSITION_BITS-1:0] char_idx_q;
	logic [POSITION_BITS-1:0] ldi_q;
	logic [31:0]              bytes_q;
	logic                     disc_q;

	// Next-state values and decode results.
	char_class_t              cls;
	logic                     nul_term;
	logic                     ends;
	logic [POSITION_BITS-1:0] idx_inc;
	logic [38:0]              mul85;
	logic [33:0]              acc5;
	logic [31:0]              gv_d;
	logic [2:0]               cnt_d;
	logic [POSITION_BITS-1:0] idx_d;
	logic [POSITION_BITS-1:0] ldi_d;
	logic                     disc_d;
	logic [2:0]               inc;
	logic [32:0]              total_sum;
	logic [31:0]              total_sat;
	logic                     has_res;
	logic                     advance;
	head_t                    head_c;
	logic [31:0]              err_pos_c;
	logic                     fin_c;

	// Positions wider than the result field saturate at all ones.
	function automatic logic [31:0] clip_pos(input logic [POSITION_BITS-1:0] p);
		logic [POSITION_BITS+31:0] w;
		w = {32'b0, p};
		return (|w[POSITION_BITS+31:32]) ? '1 : w[31:0];
	endfunction

	// One character moves on once the result side can take its results.
	assign advance    = valid_s1 && (bundle_ready || !has_res);
	assign push       = advance && has_res;
	assign text_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			char_s1 <= text_char;
			eot_s1  <= end_of_text;
		end
	end

	// Group arithmetic: one multiply by 85 shared by the digit and the group paths.
	assign cls      = classify(char_s1);
	assign nul_term = cls.is_nul && stop_q;
	assign ends     = eot_s1 || nul_term;
	assign idx_inc  = (char_idx_q == '1) ? char_idx_q : char_idx_q + 1'b1;
	assign mul85    = 39'(gv_q) * 39'(85);
	assign acc5     = mul85[33:0] + 34'(cls.value);

	always_comb begin
		gv_d      = gv_q;
		cnt_d     = cnt_q;
		idx_d     = char_idx_q;
		ldi_d     = ldi_q;
		disc_d    = disc_q;
		inc       = 3'd0;
		head_c    = HEAD_NONE;
		err_pos_c = '0;
		fin_c     = 1'b0;
		if (!disc_q) begin
			idx_d = idx_inc;
			if (nul_term || cls.is_space) begin
				// Terminator or whitespace: no digit.
			end else if (!cls.is_digit) begin
				head_c    = HEAD_ERROR;
				err_pos_c = clip_pos(idx_inc);
				disc_d    = 1'b1;
			end else if (cnt_q < 3'd4) begin
				ldi_d = idx_inc;
				gv_d  = acc5[31:0];
				cnt_d = cnt_q + 3'd1;
			end else if (gv_q > GROUP4_MAX) begin
				head_c    = HEAD_ERROR;
				err_pos_c = clip_pos(ldi_q);
				disc_d    = 1'b1;
			end else if (|acc5[33:32]) begin
				head_c    = HEAD_ERROR;
				err_pos_c = clip_pos(idx_inc);
				disc_d    = 1'b1;
			end else begin
				head_c = HEAD_BYTES;
				gv_d   = '0;
				cnt_d  = 3'd0;
				inc    = 3'd4;
			end
			fin_c = ends && !disc_d;
			// A short final group adds one byte fewer than it has digits.
			if (fin_c && cnt_d >= 3'd2) begin
				inc = cnt_d - 3'd1;
			end
		end
	end

	assign total_sum = {1'b0, bytes_q} + 33'(inc);
	assign total_sat = total_sum[32] ? '1 : total_sum[31:0];
	assign has_res   = (head_c != HEAD_NONE) || fin_c;

	// Bundle fields in declaration order: head, err_pos, word, fin, fin_cnt, fin_gv,
	// fin_ldi, fin_total.
	assign bundle = {head_c, err_pos_c, acc5[31:0], fin_c, cnt_d, gv_d, clip_pos(ldi_d),
		total_sat};

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 1'b0;
		end else if (cfg_we) begin
			stop_q <= cfg_wdata;
		end
	end

	// Message state; the end of a message returns everything to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_q       <= '0;
			cnt_q      <= '0;
			char_idx_q <= '0;
			ldi_q      <= '0;
			bytes_q    <= '0;
			disc_q     <= 1'b0;
		end else if (advance) begin
			if (ends) begin
				gv_q       <= '0;
				cnt_q      <= '0;
				char_idx_q <= '0;
				ldi_q      <= '0;
				bytes_q    <= '0;
				disc_q     <= 1'b0;
			end else begin
				gv_q       <= gv_d;
				cnt_q      <= cnt_d;
				char_idx_q <= idx_d;
				ldi_q      <= ldi_d;
				bytes_q    <= total_sat;
				disc_q     <= disc_d;
			end
		end
	end

endmodule

// ----- src/b85_emit.sv -----
module b85_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b85_pkg::bundle_t bundle,
	output logic             bundle_ready,
	input  logic             result_ready,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic [7:0]       data_byte,
	output logic [31:0]      error_position,
	output logic [31:0]      byte_total,
	output logic             run_end
);
	import b85_pkg::*;

	// Held bundle and the index of the next result to send.
	logic        bvalid_q;
	bundle_t     b_q;
	logic [2:0]  idx_q;

	// Output register.
	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	logic [31:0] pos_q;
	logic [31:0] total_q;
	logic        end_q;

	// Final group decode.
	logic [19:0] mult;
	logic [33:0] pad;
	logic [23:0] low_mask;
	logic [23:0] thr;
	logic [51:0] prod;
	logic [33:0] padded;
	logic [23:0] low_r;
	logic        tail_group;
	logic        tail_fail;
	logic [2:0]  tail_bytes;

	// Sequencing.
	logic [2:0]  head_n;
	logic [2:0]  fin_n;
	logic [2:0]  res_n;
	logic [2:0]  j;
	logic        last;
	logic        load;
	kind_t       cur_kind;
	logic [7:0]  cur_byte;
	logic [31:0] cur_pos;
	logic [31:0] cur_total;

	// Scale the short group up to five digits; the pad fills the dropped bytes.
	always_comb begin
		unique case (b_q.fin_cnt)
			3'd2: begin
				mult     = 20'd614125;
				pad      = 34'h0_00FF_FFFF;
				low_mask = 24'hFF_FFFF;
				thr      = 24'd16163091;
			end
			3'd3: begin
				mult     = 20'd7225;
				pad      = 34'h0_0000_FFFF;
				low_mask = 24'h00_FFFF;
				thr      = 24'd58311;
			end
			3'd4: begin
				mult     = 20'd85;
				pad      = 34'h0_0000_00FF;
				low_mask = 24'h00_00FF;
				thr      = 24'd171;
			end
			default: begin
				mult     = 20'd0;
				pad      = '0;
				low_mask = '0;
				thr      = '0;
			end
		endcase
	end

	// The group is canonical when rounding up to whole bytes stays inside its last digit.
	assign prod       = 52'(b_q.fin_gv) * 52'(mult);
	assign padded     = prod[33:0] + pad;
	assign low_r      = prod[23:0] & low_mask;
	assign tail_group = b_q.fin_cnt >= 3'd2;
	assign tail_fail  = (b_q.fin_cnt == 3'd1) ||
		(tail_group && ((|padded[33:32]) || (low_r != '0 && low_r <= thr)));
	assign tail_bytes = tail_group ? b_q.fin_cnt - 3'd1 : 3'd0;

	// Number of results held and which one is next.
	always_comb begin
		unique case (b_q.head)
			HEAD_BYTES: head_n = 3'd4;
			HEAD_ERROR: head_n = 3'd1;
			default:    head_n = 3'd0;
		endcase
		if (!b_q.fin) begin
			fin_n = 3'd0;
		end else if (tail_fail) begin
			fin_n = 3'd1;
		end else begin
			fin_n = tail_bytes + 3'd1;
		end
	end

	assign res_n = head_n + fin_n;
	assign j     = idx_q - head_n;
	assign last  = idx_q == res_n - 3'd1;

	// Select the next result.
	always_comb begin
		cur_kind  = KIND_BYTE;
		cur_byte  = '0;
		cur_pos   = '0;
		cur_total = '0;
		if (idx_q < head_n) begin
			if (b_q.head == HEAD_ERROR) begin
				cur_kind = KIND_ERROR;
				cur_pos  = b_q.err_pos;
			end else begin
				unique case (idx_q[1:0])
					2'd0: cur_byte = b_q.word[31:24];
					2'd1: cur_byte = b_q.word[23:16];
					2'd2: cur_byte = b_q.word[15:8];
					2'd3: cur_byte = b_q.word[7:0];
				endcase
			end
		end else if (tail_fail) begin
			cur_kind = KIND_ERROR;
			cur_pos  = b_q.fin_ldi;
		end else if (j < tail_bytes) begin
			unique case (j[1:0])
				2'd0:    cur_byte = padded[31:24];
				2'd1:    cur_byte = padded[23:16];
				default: cur_byte = padded[15:8];
			endcase
		end else begin
			cur_kind  = KIND_DONE;
			cur_total = b_q.fin_total;
		end
	end

	assign load         = bvalid_q && (!out_valid_q || result_ready);
	assign bundle_ready = !bvalid_q || (load && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			idx_q    <= '0;
		end else if (push) begin
			bvalid_q <= 1'b1;
			idx_q    <= '0;
		end else if (load) begin
			if (last) begin
				bvalid_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			b_q <= bundle;
		end
	end

	// Output register: a result waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= cur_kind;
			byte_q  <= cur_byte;
			pos_q   <= cur_pos;
			total_q <= cur_total;
			end_q   <= last;
		end
	end

	assign result_valid   = out_valid_q;
	assign result_kind    = kind_q;
	assign data_byte      = byte_q;
	assign error_position = pos_q;
	assign byte_total     = total_q;
	assign run_end        = end_q;

endmodule

// ----- src/base85_stream_decoder_unit.sv -----
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-----------------------------------------------
// text     | text_valid / text_ready     | text_char, end_of_text
// result   | result_valid / result_ready | result_kind, data_byte, error_position,
//          |                             | byte_total, run_end
// config   | cfg_we (no wait)            | cfg_wdata (stop_at_nul)
//
// A character passes an input register, the decode and group arithmetic, a result
// bundle register and an output register before its first result is offered.
// While the result side is ready, characters that give at most one result go through
// at one per cycle, and a character that gives n results holds the result side until
// all n are sent, one result per cycle.
// Reset clears all state at once; there is no clearing pass.
// A stalled result side backs up through the bundle register into text_ready.
module base85_stream_decoder_unit #(
	parameter int POSITION_BITS = b85_pkg::POSITION_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_char,
	input  logic        end_of_text,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  data_byte,
	output logic [31:0] error_position,
	output logic [31:0] byte_total,
	output logic        run_end
);
	import b85_pkg::*;

	logic    push;
	logic    bundle_ready;
	bundle_t bundle;

	// Character decode and message state.
	b85_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text_char   (text_char),
		.end_of_text (end_of_text),
		.bundle_ready(bundle_ready),
		.push        (push),
		.bundle      (bundle)
	);

	// Result sequencing and the final group check.
	b85_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.bundle        (bundle),
		.bundle_ready  (bundle_ready),
		.result_ready  (result_ready),
		.result_valid  (result_valid),
		.result_kind   (result_kind),
		.data_byte     (data_byte),
		.error_position(error_position),
		.byte_total    (byte_total),
		.run_end       (run_end)
	);

	// A done result always closes the results of its character.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_DONE |-> run_end)
		else $error("done result not marked as the last of its character");

	// An error result always closes the results of its character.
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_ERROR |-> run_end)
		else $error("error result not marked as the last of its character");

	// Results of one character follow each other without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !run_end |=> result_valid)
		else $error("gap inside the results of one character");

endmodule

// ----- bench/testbench.sv -----
module testbench;

	import b85_pkg::*;

	// Cycles without any transfer on either channel before the run is abandoned.
	localparam int QUIET_LIMIT = 2000;

	// Classes of a raw character that are not digits.
	localparam int CH_NUL     = -3;
	localparam int CH_SPACE   = -2;
	localparam int CH_INVALID = -1;

	// A four-digit prefix above this value cannot take a fifth digit.
	localparam logic [31:0] FOUR_DIGIT_LIMIT = 32'h0303_0303;

	// Character codes of digit values 62 to 84, value 62 in the top byte.
	localparam logic [23*8-1:0] PUNCT_CODES = {
		8'd33, 8'd35, 8'd36, 8'd37, 8'd38, 8'd40, 8'd41, 8'd42, 8'd43, 8'd45, 8'd59, 8'd60,
		8'd61, 8'd62, 8'd63, 8'd64, 8'd94, 8'd95, 8'd96, 8'd123, 8'd124, 8'd125, 8'd126
	};

	// One result item as the block should deliver it.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [31:0] pos;
		logic [31:0] total;
		logic        last;
	} result_rec_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic        cfg_wdata    = 1'b0;
	logic        text_valid   = 1'b0;
	logic        text_ready;
	logic [7:0]  text_char    = 8'd0;
	logic        end_of_text  = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  data_byte;
	logic [31:0] error_position;
	logic [31:0] byte_total;
	logic        run_end;

	// Decoder state as the block should hold it.
	logic [31:0] grp_acc    = '0;
	int unsigned grp_digits = 0;
	logic [31:0] pos_count  = '0;
	logic [31:0] last_pos   = '0;
	logic [6:0]  last_val   = '0;
	logic [31:0] byte_count = '0;
	logic        dropping   = 1'b0;
	logic        nul_ends   = 1'b0;

	// Results of the character being decoded, and all results still owed.
	result_rec_t burst [0:4];
	int          burst_len;
	result_rec_t decoder_results_due [$];

	// Text of the message about to be sent.
	logic [7:0] msg_text [$];

	// Idling controls shared by the sender, the receiver and the tests.
	logic tx_gaps     = 1'b1;
	logic rx_stalls   = 1'b1;
	int   hold_cycles = 0;

	int chars_sent      = 0;
	int messages_sent   = 0;
	int results_checked = 0;
	int bytes_decoded   = 0;
	int errors_flagged  = 0;
	int clean_ends      = 0;
	int mismatches      = 0;
	int quiet_cycles    = 0;

	base85_stream_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.text_valid     (text_valid),
		.text_ready     (text_ready),
		.text_char      (text_char),
		.end_of_text    (end_of_text),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result_kind    (result_kind),
		.data_byte      (data_byte),
		.error_position (error_position),
		.byte_total     (byte_total),
		.run_end        (run_end)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Character code of a digit value.
	function automatic logic [7:0] digit_char(input int v);
		if (v < 10) return 8'(48 + v);
		if (v < 36) return 8'(55 + v);
		if (v < 62) return 8'(61 + v);
		return PUNCT_CODES[(84 - v) * 8 +: 8];
	endfunction

	// Digit value of a character, or one of the non-digit classes.
	function automatic int char_value(input logic [7:0] c);
		if (c == 8'd0) return CH_NUL;
		if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) return CH_SPACE;
		for (int v = 0; v < 85; v++) begin
			if (digit_char(v) == c) return v;
		end
		return CH_INVALID;
	endfunction

	// Length of one idle stretch: mostly short, now and then long.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(1, 2);
		if (r < 92) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// A random whitespace character.
	function automatic logic [7:0] pick_space();
		int sel;
		sel = $urandom_range(0, 5);
		return (sel == 5) ? 8'd32 : 8'(9 + sel);
	endfunction

	task automatic add_result(input kind_t k, input logic [7:0] b, input logic [31:0] p,
			input logic [31:0] t);
		burst[burst_len] = '{kind: k, data: b, pos: p, total: t, last: 1'b0};
		burst_len++;
	endtask

	task automatic emit_byte(input logic [7:0] b);
		add_result(KIND_BYTE, b, '0, '0);
		if (byte_count != '1) byte_count++;
		bytes_decoded++;
	endtask

	// An error ends decoding until the message is over.
	task automatic flag_error(input logic [31:0] p);
		add_result(KIND_ERROR, '0, p, '0);
		dropping = 1'b1;
		errors_flagged++;
	endtask

	// One digit: either it extends the group or it completes five digits.
	task automatic take_digit(input int v);
		logic [63:0] wide;
		if (grp_digits < 4) begin
			last_pos = pos_count;
			last_val = 7'(v);
			grp_acc  = grp_acc * 85 + 32'(v);
			grp_digits++;
		end else if (grp_acc > FOUR_DIGIT_LIMIT) begin
			flag_error(last_pos);
		end else begin
			wide = 64'(grp_acc) * 85 + 64'(v);
			if (wide > 64'hFFFF_FFFF) begin
				flag_error(pos_count);
			end else begin
				for (int i = 3; i >= 0; i--) emit_byte(wide[8 * i +: 8]);
				grp_acc    = '0;
				grp_digits = 0;
			end
		end
	endtask

	// End of message: the partial group must be in range and canonical.
	task automatic close_message();
		logic [63:0] acc;
		logic [63:0] div;
		logic [63:0] keep;
		if (grp_digits == 1) begin
			flag_error(last_pos);
			return;
		end
		if (grp_digits >= 2) begin
			acc = 64'(grp_acc);
			for (int i = grp_digits; i < 4; i++) acc = acc * 85;
			if (acc > 64'h0303_0300 || (grp_digits == 3 && acc > 64'h0303_0000) ||
					(grp_digits == 2 && acc > 64'h0300_0000)) begin
				flag_error(last_pos);
				return;
			end
			acc = acc * 85 + (64'hFF_FFFF >> ((grp_digits - 2) * 8));
			case (grp_digits)
				2: begin
					keep = 64'hFF00_0000;
					div  = 64'd614125;
				end
				3: begin
					keep = 64'hFFFF_0000;
					div  = 64'd7225;
				end
				default: begin
					keep = 64'hFFFF_FF00;
					div  = 64'd85;
				end
			endcase
			acc = acc & keep;
			if ((acc / div) % 85 != 64'(last_val)) begin
				flag_error(last_pos);
				return;
			end
			for (int i = 0; i < grp_digits - 1; i++) emit_byte(acc[24 - 8 * i +: 8]);
		end
		add_result(KIND_DONE, '0, '0, byte_count);
		clean_ends++;
	endtask

	// Works out the results of one accepted character and queues them.
	task automatic decode_text_char(input logic [7:0] c, input logic eot);
		int   cls;
		logic ends;
		burst_len = 0;
		cls  = char_value(c);
		ends = eot || (cls == CH_NUL && nul_ends);
		if (!dropping) begin
			if (pos_count != '1) pos_count++;
			if (cls == CH_INVALID || (cls == CH_NUL && !nul_ends)) flag_error(pos_count);
			else if (cls >= 0) take_digit(cls);
			if (ends && !dropping) close_message();
		end
		if (ends) begin
			grp_acc    = '0;
			grp_digits = 0;
			pos_count  = '0;
			last_pos   = '0;
			last_val   = '0;
			byte_count = '0;
			dropping   = 1'b0;
		end
		if (burst_len > 0) burst[burst_len - 1].last = 1'b1;
		for (int i = 0; i < burst_len; i++) decoder_results_due.push_back(burst[i]);
	endtask

	// Every accepted character is decoded at the edge of its transfer.
	always @(posedge clk) begin
		if (arst_n && text_valid && text_ready) decode_text_char(text_char, end_of_text);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at result %0d: %s is %0h, expected %0h",
				results_checked, what, got, want);
	endtask

	// Each result transfer is compared with the oldest result owed.
	always @(posedge clk) begin : check_results
		result_rec_t want;
		if (arst_n && result_valid && result_ready) begin
			results_checked++;
			if (decoder_results_due.size() == 0) begin
				report_mismatch("unexpected result, kind", 32'(result_kind), '0);
			end else begin
				want = decoder_results_due.pop_front();
				if (result_kind !== want.kind)
					report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
				if (data_byte !== want.data)
					report_mismatch("data_byte", 32'(data_byte), 32'(want.data));
				if (error_position !== want.pos)
					report_mismatch("error_position", error_position, want.pos);
				if (byte_total !== want.total)
					report_mismatch("byte_total", byte_total, want.total);
				if (run_end !== want.last)
					report_mismatch("run_end", 32'(run_end), 32'(want.last));
			end
		end
	end

	// Result side: random stalls, and a long hold-off when a test asks for one.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				result_ready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				stall_left = idle_length() - 1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Watchdog: gives up when no transfer has happened for too long.
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (text_valid && text_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no transfer for %0d cycles, %0d results still owed",
			QUIET_LIMIT, decoder_results_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Offers one character and waits for its transfer; valid stays high after it.
	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid  <= 1'b1;
		text_char   <= c;
		end_of_text <= last;
		do @(posedge clk); while (!text_ready);
		if (char_value(c) != CH_SPACE) chars_sent++;
	endtask

	task automatic send_message(input logic mark_last);
		for (int i = 0; i < msg_text.size(); i++)
			send_char(msg_text[i], mark_last && (i == msg_text.size() - 1));
		messages_sent++;
	endtask

	// Stops offering and waits until every owed result has arrived.
	task automatic drain();
		text_valid <= 1'b0;
		@(posedge clk);
		while (decoder_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_nul_mode(input logic v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		nul_ends = v;
	endtask

	task automatic load_text(input string s);
		msg_text.delete();
		for (int i = 0; i < s.len(); i++) msg_text.push_back(s[i]);
	endtask

	// Appends a character, now and then after a stray whitespace character.
	task automatic add_char(input logic [7:0] c);
		if ($urandom_range(0, 99) < 12) msg_text.push_back(pick_space());
		msg_text.push_back(c);
	endtask

	// Encodes random bytes: four per group of five digits, a short tail at the end.
	task automatic encode_bytes(input int nbytes);
		logic [31:0] w;
		logic [6:0]  d [5];
		int          k;
		int          sel;
		int          taken;
		taken = 0;
		while (taken < nbytes) begin
			k   = (nbytes - taken >= 4) ? 4 : nbytes - taken;
			sel = $urandom_range(0, 9);
			w   = (sel == 0) ? '0 : (sel == 1) ? '1 : $urandom();
			if (k < 4) w = w & ~(32'hFFFF_FFFF >> (8 * k));
			for (int i = 4; i >= 0; i--) begin
				d[i] = 7'(w % 85);
				w    = w / 85;
			end
			for (int i = 0; i <= k; i++) add_char(digit_char(d[i]));
			taken += k;
		end
	endtask

	// A complete group whose value is too large, at the fourth or the fifth digit.
	task automatic push_overflow_group();
		if ($urandom_range(0, 1) == 0) begin
			repeat (4) add_char(digit_char(84));
			add_char(digit_char($urandom_range(0, 84)));
		end else begin
			add_char(digit_char(82));
			add_char(digit_char(23));
			add_char(digit_char(54));
			add_char(digit_char(12));
			add_char(digit_char($urandom_range(1, 84)));
		end
	endtask

	// Mostly well-formed messages, the rest noise or damaged text.
	task automatic build_random_message(output logic mark_last);
		int sel;
		int nbytes;
		int n;
		msg_text.delete();
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			n = $urandom_range(1, 8);
			repeat (n) msg_text.push_back(8'($urandom_range(0, 255)));
		end else begin
			if (sel >= 25 && sel < 32) push_overflow_group();
			nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 9);
			encode_bytes(nbytes);
			if (sel < 18 && msg_text.size() > 0) begin
				n = $urandom_range(0, msg_text.size() - 1);
				msg_text[n] = 8'($urandom_range(0, 255));
			end else if (sel >= 18 && sel < 25) begin
				add_char(digit_char($urandom_range(0, 84)));
			end else if (sel >= 32 && sel < 40) begin
				n = $urandom_range(2, 4);
				repeat (n) add_char(digit_char($urandom_range(0, 84)));
			end
		end
		// Close with a NUL where that ends a message, else mark the last character.
		if (nul_ends && $urandom_range(0, 1) == 0) begin
			msg_text.push_back(8'h00);
			mark_last = 1'($urandom_range(0, 1));
		end else begin
			if (msg_text.size() == 0 || $urandom_range(0, 4) == 0) msg_text.push_back(pick_space());
			mark_last = 1'b1;
		end
	endtask

	// Extremes and ways in which a message can end or fail, in both NUL modes.
	task automatic test_directed_cases();
		// Largest group, giving the most results for one character.
		load_text("|NsC0");
		send_message(1'b1);
		// Fifth digit takes the group past 32 bits.
		load_text("|NsC1");
		send_message(1'b1);
		// Empty message ended on whitespace.
		load_text(" ");
		send_message(1'b1);
		// Lone final digit.
		load_text("0");
		send_message(1'b1);
		// Invalid character with every bit set.
		msg_text.delete();
		msg_text.push_back(8'hFF);
		send_message(1'b1);
		// NUL is invalid in this mode; the character after it is discarded.
		load_text("0");
		msg_text.push_back(8'h00);
		msg_text.push_back(8'h35);
		send_message(1'b1);
		// Final group out of range, then one whose last digit is not canonical.
		load_text("~~");
		send_message(1'b1);
		load_text("01");
		send_message(1'b1);
		// Canonical one-byte tail with whitespace inside it.
		load_text("0\tR");
		send_message(1'b1);
		// NUL as terminator, after a tail and on its own with the end mark.
		set_nul_mode(1'b1);
		load_text("00");
		msg_text.push_back(8'h00);
		send_message(1'b0);
		msg_text.delete();
		msg_text.push_back(8'h00);
		send_message(1'b1);
	endtask

	task automatic test_random_stream(input logic nul_mode, input int budget);
		int   stop_at;
		logic mark_last;
		set_nul_mode(nul_mode);
		stop_at = chars_sent + budget;
		while (chars_sent < stop_at) begin
			tx_gaps   = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			build_random_message(mark_last);
			send_message(mark_last);
		end
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
	endtask

	// The result side holds off while characters keep coming, so the block backs up.
	task automatic test_result_backpressure();
		set_nul_mode(1'b0);
		tx_gaps     = 1'b0;
		rx_stalls   = 1'b0;
		hold_cycles = 300;
		repeat (5) begin
			msg_text.delete();
			encode_bytes(8);
			msg_text.push_back(pick_space());
			send_message(1'b1);
		end
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_stream(1'b0, 65);
		test_random_stream(1'b1, 65);
		test_result_backpressure();
		drain();
		$display("Sent %0d characters in %0d messages with both NUL modes; checked %0d results.",
			chars_sent, messages_sent, results_checked);
		$display("Results owed: %0d bytes, %0d errors, %0d clean ends; %0d mismatches.",
			bytes_decoded, errors_flagged, clean_ends, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
